@@ src/qsih_pkg.sv @@
// Shared types and constants for the quicksort / insertion-sort block.
// No dependencies; imported by qsih_datapath, qsih_ctrl, the top level and the testbench.
`default_nettype none
package qsih_pkg;

  localparam int unsigned MAX_KEYS    = 1024;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned STACK_DEPTH = 64;

  localparam int unsigned ADDR_W   = $clog2(MAX_KEYS);
  localparam int unsigned POS_W    = ADDR_W + 1;
  localparam int unsigned SP_W     = $clog2(STACK_DEPTH);
  localparam int unsigned FILL_W   = SP_W + 1;
  localparam int unsigned RANGE_W  = 2 * POS_W;
  localparam int unsigned THR_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IDX_W    = 10;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef enum logic [0:0] {
    CFG_SIGNED_KEYS = 1'b0,
    CFG_INS_THR     = 1'b1
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_SORTED    = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_BAD_INDEX = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_OUT_RD, OP_DONE, OP_PUSH_ALL, OP_POP, OP_POP_LD,
    OP_INS_INIT, OP_INS_RDI, OP_INS_LDI, OP_INS_RDJ, OP_INS_WRI, OP_INS_SHIFT,
    OP_PV_RD, OP_PV_LD, OP_PA_RD, OP_PA_SKIP, OP_PA_SELF, OP_PA_RDP,
    OP_PA_SW1, OP_PA_SW2, OP_PF_RD, OP_PF_W1, OP_PF_W2, OP_PUSH1, OP_PUSH2
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_OUT, S_SORT_START, S_POP, S_POP_LD, S_LEN,
    S_INS_CHK, S_INS_LDI, S_INS_J, S_INS_CMP,
    S_PV_LD, S_PA_RD, S_PA_CMP, S_PA_SW1, S_PA_SW2,
    S_PF_W1, S_PF_W2, S_SPLIT, S_PUSH2
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_mode;
    logic in_last;
    logic idx_ok;
    logic n_le1;
    logic fill_zero;
    logic len_le1;
    logic len_le_thr;
    logic i_lt_e;
    logic j_gt_b;
    logic less_ins;
    logic it_lt_last;
    logic less_piv;
    logic p_eq_it;
    logic overflow;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/qsih_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module qsih_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ src/qsih_datapath.sv @@
// Datapath: key store, range stack, sort pointers, config and result register.
// Depends on qsih_pkg and qsih_ram; driven by commands from qsih_ctrl.
`default_nettype none
module qsih_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [qsih_pkg::THR_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_mode_i,
  input  wire logic                          in_last_i,
  input  wire logic [qsih_pkg::KEY_WIDTH-1:0] in_key_i,
  input  wire logic [qsih_pkg::IDX_W-1:0]    in_index_i,
  input  wire logic                          out_ready_i,
  input  wire qsih_pkg::dp_cmd_t             cmd_i,
  output qsih_pkg::dp_stat_t                 stat_o,
  output logic                               out_valid_o,
  output logic [qsih_pkg::KEY_WIDTH-1:0]     out_value_o,
  output logic [qsih_pkg::STATUS_W-1:0]      out_status_o,
  output logic [qsih_pkg::POS_W-1:0]         out_count_o
);
  import qsih_pkg::*;

  logic                 signed_q;
  logic [THR_W-1:0]     thr_q;
  logic [POS_W-1:0]     count_q, count_d;
  logic                 load_done_q, load_done_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [POS_W-1:0]     b_q, b_d, e_q, e_d, i_q, i_d, j_q, j_d, p_q, p_d, it_q, it_d;
  logic [KEY_WIDTH-1:0] pivot_q, pivot_d, ins_q, ins_d, tmp_q, tmp_d;
  logic                 ov_q, ov_d;
  logic [KEY_WIDTH-1:0] ov_value_q, ov_value_d;
  logic [STATUS_W-1:0]  ov_status_q, ov_status_d;
  logic [POS_W-1:0]     ov_count_q, ov_count_d;

  logic                 key_we, key_re;
  logic [ADDR_W-1:0]    key_waddr, key_raddr;
  logic [KEY_WIDTH-1:0] key_wdata, key_rdata;
  logic                 stk_we, stk_re;
  logic [SP_W-1:0]      stk_waddr, stk_raddr;
  logic [RANGE_W-1:0]   stk_wdata, stk_rdata;

  logic [POS_W-1:0]     cnt0, len, split, e_m1, j_m1;
  logic                 full, lo_first;
  logic [FILL_W:0]      fill_p2;

  function automatic logic key_less(input logic a_signed, input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
    logic [KEY_WIDTH-1:0] fa, fb;
    fa = a;
    fb = b;
    if (a_signed) begin
      fa[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
      fb[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
    end
    return fa < fb;
  endfunction

  qsih_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .re_i(key_re), .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  qsih_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign cnt0     = load_done_q ? '0 : count_q;
  assign full     = cnt0 >= POS_W'(MAX_KEYS);
  assign len      = e_q - b_q;
  assign e_m1     = e_q - POS_W'(1);
  assign j_m1     = j_q - POS_W'(1);
  // move the split past begin when the pivot lands there
  assign split    = (p_q == b_q) ? b_q + POS_W'(1) : p_q;
  assign lo_first = (split - b_q) < (e_q - split);
  assign fill_p2  = {1'b0, fill_q} + (FILL_W+1)'(2);

  always_comb begin
    stat_o.out_free   = !ov_q || out_ready_i;
    stat_o.in_mode    = in_mode_i;
    stat_o.in_last    = in_last_i;
    stat_o.idx_ok     = {1'b0, in_index_i} < count_q;
    stat_o.n_le1      = count_q <= POS_W'(1);
    stat_o.fill_zero  = fill_q == '0;
    stat_o.len_le1    = len <= POS_W'(1);
    stat_o.len_le_thr = len <= POS_W'(thr_q);
    stat_o.i_lt_e     = i_q < e_q;
    stat_o.j_gt_b     = j_q > b_q;
    stat_o.less_ins   = key_less(signed_q, ins_q, key_rdata);
    stat_o.it_lt_last = it_q < e_m1;
    stat_o.less_piv   = key_less(signed_q, key_rdata, pivot_q);
    stat_o.p_eq_it    = p_q == it_q;
    stat_o.overflow   = fill_p2 > (FILL_W+1)'(STACK_DEPTH);
  end

  always_comb begin
    count_d = count_q;  load_done_d = load_done_q;  fill_d = fill_q;
    b_d = b_q;  e_d = e_q;  i_d = i_q;  j_d = j_q;  p_d = p_q;  it_d = it_q;
    pivot_d = pivot_q;  ins_d = ins_q;  tmp_d = tmp_q;
    ov_d = ov_q && !out_ready_i;
    ov_value_d = ov_value_q;  ov_status_d = ov_status_q;  ov_count_d = ov_count_q;
    key_we = 1'b0;  key_waddr = '0;  key_wdata = '0;  key_re = 1'b0;  key_raddr = '0;
    stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;  stk_re = 1'b0;  stk_raddr = '0;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        if (!in_mode_i) begin
          load_done_d = in_last_i;
          count_d     = full ? cnt0 : cnt0 + POS_W'(1);
          key_we      = !full;
          key_waddr   = cnt0[ADDR_W-1:0];
          key_wdata   = in_key_i;
          if (!in_last_i) begin
            ov_d        = 1'b1;
            ov_value_d  = '0;
            ov_status_d = full ? ST_FULL : ST_STORED;
            ov_count_d  = count_d;
          end
        end else if (stat_o.idx_ok) begin
          key_re    = 1'b1;
          key_raddr = in_index_i[ADDR_W-1:0];
        end else begin
          ov_d        = 1'b1;
          ov_value_d  = '0;
          ov_status_d = ST_BAD_INDEX;
          ov_count_d  = count_q;
        end
      end
      OP_OUT_RD: begin
        ov_d = 1'b1;  ov_value_d = key_rdata;  ov_status_d = ST_READ_OK;  ov_count_d = count_q;
      end
      OP_DONE: begin
        ov_d = 1'b1;  ov_value_d = '0;  ov_status_d = cmd_i.status;  ov_count_d = count_q;
      end
      OP_PUSH_ALL: begin
        stk_we = 1'b1;  stk_waddr = '0;  stk_wdata = {POS_W'(0), count_q};
        fill_d = FILL_W'(1);
      end
      OP_POP: begin
        fill_d    = fill_q - FILL_W'(1);
        stk_re    = 1'b1;
        stk_raddr = fill_d[SP_W-1:0];
      end
      OP_POP_LD: begin
        b_d = stk_rdata[RANGE_W-1:POS_W];
        e_d = stk_rdata[POS_W-1:0];
      end
      OP_INS_INIT: i_d = b_q + POS_W'(1);
      OP_INS_RDI: begin
        key_re = 1'b1;  key_raddr = i_q[ADDR_W-1:0];
      end
      OP_INS_LDI: begin
        ins_d = key_rdata;  j_d = i_q;
      end
      OP_INS_RDJ: begin
        key_re = 1'b1;  key_raddr = j_m1[ADDR_W-1:0];
      end
      OP_INS_WRI: begin
        key_we = 1'b1;  key_waddr = j_q[ADDR_W-1:0];  key_wdata = ins_q;
        i_d = i_q + POS_W'(1);
      end
      OP_INS_SHIFT: begin
        key_we = 1'b1;  key_waddr = j_q[ADDR_W-1:0];  key_wdata = key_rdata;
        j_d = j_m1;
      end
      OP_PV_RD: begin
        key_re = 1'b1;  key_raddr = e_m1[ADDR_W-1:0];
      end
      OP_PV_LD: begin
        pivot_d = key_rdata;  p_d = b_q;  it_d = b_q;
      end
      OP_PA_RD: begin
        key_re = 1'b1;  key_raddr = it_q[ADDR_W-1:0];
      end
      OP_PA_SKIP: it_d = it_q + POS_W'(1);
      OP_PA_SELF: begin
        p_d = p_q + POS_W'(1);  it_d = it_q + POS_W'(1);
      end
      OP_PA_RDP: begin
        tmp_d  = key_rdata;
        key_re = 1'b1;  key_raddr = p_q[ADDR_W-1:0];
      end
      OP_PA_SW1: begin
        key_we = 1'b1;  key_waddr = it_q[ADDR_W-1:0];  key_wdata = key_rdata;
      end
      OP_PA_SW2: begin
        key_we = 1'b1;  key_waddr = p_q[ADDR_W-1:0];  key_wdata = tmp_q;
        p_d = p_q + POS_W'(1);  it_d = it_q + POS_W'(1);
      end
      OP_PF_RD: begin
        key_re = 1'b1;  key_raddr = p_q[ADDR_W-1:0];
      end
      OP_PF_W1: begin
        key_we = 1'b1;  key_waddr = e_m1[ADDR_W-1:0];  key_wdata = key_rdata;
      end
      OP_PF_W2: begin
        key_we = 1'b1;  key_waddr = p_q[ADDR_W-1:0];  key_wdata = pivot_q;
      end
      OP_PUSH1: begin
        stk_we = 1'b1;  stk_waddr = fill_q[SP_W-1:0];
        stk_wdata = lo_first ? {b_q, split} : {split, e_q};
        fill_d = fill_q + FILL_W'(1);
      end
      OP_PUSH2: begin
        stk_we = 1'b1;  stk_waddr = fill_q[SP_W-1:0];
        stk_wdata = lo_first ? {split, e_q} : {b_q, split};
        fill_d = fill_q + FILL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q    <= 1'b0;
      thr_q       <= THR_RESET;
      count_q     <= '0;
      load_done_q <= 1'b0;
      fill_q      <= '0;
      pivot_q     <= '0;
      ins_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SIGNED_KEYS: signed_q <= cfg_wdata_i[0];
          CFG_INS_THR:     thr_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      count_q     <= count_d;
      load_done_q <= load_done_d;
      fill_q      <= fill_d;
      pivot_q     <= pivot_d;
      ins_q       <= ins_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;  e_q <= e_d;  i_q <= i_d;  j_q <= j_d;  p_q <= p_d;  it_q <= it_d;
    tmp_q       <= tmp_d;
    ov_value_q  <= ov_value_d;
    ov_status_q <= ov_status_d;
    ov_count_q  <= ov_count_d;
  end

  assign out_valid_o  = ov_q;
  assign out_value_o  = ov_value_q;
  assign out_status_o = ov_status_q;
  assign out_count_o  = ov_count_q;

endmodule
`default_nettype wire

@@ src/qsih_ctrl.sv @@
// Controller: sequences loads, reads and the in-place sort one step a cycle.
// Depends on qsih_pkg; issues commands to qsih_datapath.
`default_nettype none
module qsih_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire qsih_pkg::dp_stat_t  stat_i,
  output qsih_pkg::dp_cmd_t        cmd_o
);
  import qsih_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (stat_i.in_mode) begin
            state_d = stat_i.idx_ok ? S_RD_OUT : S_IDLE;
          end else begin
            state_d = stat_i.in_last ? S_SORT_START : S_IDLE;
          end
        end
      end
      S_RD_OUT:     state_d = S_IDLE;
      S_SORT_START: state_d = stat_i.n_le1 ? S_IDLE : S_POP;
      S_POP:        state_d = stat_i.fill_zero ? S_IDLE : S_POP_LD;
      S_POP_LD:     state_d = S_LEN;
      S_LEN: begin
        if (stat_i.len_le1)         state_d = S_POP;
        else if (stat_i.len_le_thr) state_d = S_INS_CHK;
        else                        state_d = S_PV_LD;
      end
      S_INS_CHK:    state_d = stat_i.i_lt_e ? S_INS_LDI : S_POP;
      S_INS_LDI:    state_d = S_INS_J;
      S_INS_J:      state_d = stat_i.j_gt_b ? S_INS_CMP : S_INS_CHK;
      S_INS_CMP:    state_d = stat_i.less_ins ? S_INS_J : S_INS_CHK;
      S_PV_LD:      state_d = S_PA_RD;
      S_PA_RD:      state_d = stat_i.it_lt_last ? S_PA_CMP : S_PF_W1;
      S_PA_CMP:     state_d = (stat_i.less_piv && !stat_i.p_eq_it) ? S_PA_SW1 : S_PA_RD;
      S_PA_SW1:     state_d = S_PA_SW2;
      S_PA_SW2:     state_d = S_PA_RD;
      S_PF_W1:      state_d = S_PF_W2;
      S_PF_W2:      state_d = S_SPLIT;
      S_SPLIT:      state_d = stat_i.overflow ? S_IDLE : S_PUSH2;
      S_PUSH2:      state_d = S_POP;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.status = ST_SORTED;
    unique case (state_q)
      S_IDLE:       if (in_valid_i && in_ready_o) cmd_o.op = OP_ACCEPT;
      S_RD_OUT:     cmd_o.op = OP_OUT_RD;
      S_SORT_START: begin
        if (stat_i.n_le1) begin
          cmd_o.op     = OP_DONE;
          cmd_o.status = ST_TOO_SHORT;
        end else begin
          cmd_o.op = OP_PUSH_ALL;
        end
      end
      S_POP:        cmd_o.op = stat_i.fill_zero ? OP_DONE : OP_POP;
      S_POP_LD:     cmd_o.op = OP_POP_LD;
      S_LEN: begin
        if (stat_i.len_le1)         cmd_o.op = OP_NONE;
        else if (stat_i.len_le_thr) cmd_o.op = OP_INS_INIT;
        else                        cmd_o.op = OP_PV_RD;
      end
      S_INS_CHK:    cmd_o.op = stat_i.i_lt_e ? OP_INS_RDI : OP_NONE;
      S_INS_LDI:    cmd_o.op = OP_INS_LDI;
      S_INS_J:      cmd_o.op = stat_i.j_gt_b ? OP_INS_RDJ : OP_INS_WRI;
      S_INS_CMP:    cmd_o.op = stat_i.less_ins ? OP_INS_SHIFT : OP_INS_WRI;
      S_PV_LD:      cmd_o.op = OP_PV_LD;
      S_PA_RD:      cmd_o.op = stat_i.it_lt_last ? OP_PA_RD : OP_PF_RD;
      S_PA_CMP: begin
        if (!stat_i.less_piv)    cmd_o.op = OP_PA_SKIP;
        else if (stat_i.p_eq_it) cmd_o.op = OP_PA_SELF;
        else                     cmd_o.op = OP_PA_RDP;
      end
      S_PA_SW1:     cmd_o.op = OP_PA_SW1;
      S_PA_SW2:     cmd_o.op = OP_PA_SW2;
      S_PF_W1:      cmd_o.op = OP_PF_W1;
      S_PF_W2:      cmd_o.op = OP_PF_W2;
      S_SPLIT: begin
        if (stat_i.overflow) begin
          cmd_o.op     = OP_DONE;
          cmd_o.status = ST_OVERFLOW;
        end else begin
          cmd_o.op = OP_PUSH1;
        end
      end
      S_PUSH2:      cmd_o.op = OP_PUSH2;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/quicksort_insertion_hybrid.sv @@
// Top level of the in-place key sorter: stream ports and configuration port.
// Depends on qsih_pkg, qsih_ctrl and qsih_datapath.
//
// Load words (tuser = 0) append one key each while the store has room; the
// word with tlast set also sorts the held keys in place before its result is
// given. Runs up to insertion_threshold keys use insertion sort, longer runs
// a Lomuto partition driven from a 64-entry range stack. The key store has a
// single read and a single write port, so a compare reads its key first and
// a swap reads the second key, then writes both keys. A read word (tuser = 1)
// reads the key store and passes the value through the read state into the
// result register. One word is worked on at a time; a new word is taken while
// the controller is idle and the result register is free or being emptied.
`default_nettype none
module quicksort_insertion_hybrid (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [qsih_pkg::THR_W-1:0] cfg_wdata_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [47:0]                s_axis_tdata,  // key[31:0], index[41:32], zeros
  input  wire logic                       s_axis_tuser,  // mode
  input  wire logic                       s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [47:0]                     m_axis_tdata   // value[31:0], status[34:32],
                                                         // count[45:35], zeros
);
  import qsih_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [KEY_WIDTH-1:0] out_value;
  logic [STATUS_W-1:0]  out_status;
  logic [POS_W-1:0]     out_count;

  qsih_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  qsih_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_mode_i(s_axis_tuser), .in_last_i(s_axis_tlast),
    .in_key_i(s_axis_tdata[31:0]), .in_index_i(s_axis_tdata[41:32]),
    .out_ready_i(m_axis_tready),
    .cmd_i(cmd), .stat_o(stat),
    .out_valid_o(m_axis_tvalid), .out_value_o(out_value),
    .out_status_o(out_status), .out_count_o(out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_status, out_value};

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for quicksort_insertion_hybrid: drives load and read
// words, predicts every result word with its own sorter and compares them.
// Depends on qsih_pkg and the RTL of the block only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qsih_pkg::*;

  typedef struct {
    logic [31:0] value;
    status_e     status;
    logic [10:0] count;
  } sort_result_t;

  class sort_scoreboard;
    logic [31:0]  keys [MAX_KEYS];
    int unsigned  held;
    bit           load_finished;
    bit           signed_cmp;
    int unsigned  ins_limit;
    int unsigned  ranges_lo [STACK_DEPTH];
    int unsigned  ranges_hi [STACK_DEPTH];
    sort_result_t awaited [$];
    int           errors;

    function new();
      held = 0;
      load_finished = 0;
      signed_cmp = 0;
      ins_limit = 16;
      errors = 0;
    endfunction

    function bit key_lt(logic [31:0] a, logic [31:0] b);
      return signed_cmp ? ($signed(a) < $signed(b)) : (a < b);
    endfunction

    function void insertion_run(int unsigned b, int unsigned e);
      logic [31:0] v;
      int unsigned j;
      for (int unsigned i = b + 1; i < e; i++) begin
        v = keys[i];
        j = i;
        while (j > b && key_lt(v, keys[j-1])) begin
          keys[j] = keys[j-1];
          j--;
        end
        keys[j] = v;
      end
    endfunction

    function int unsigned partition(int unsigned b, int unsigned e);
      logic [31:0] pv, t;
      int unsigned p;
      p = b;
      pv = keys[e-1];
      for (int unsigned k = b; k < e - 1; k++) begin
        if (key_lt(keys[k], pv)) begin
          t = keys[p]; keys[p] = keys[k]; keys[k] = t;
          p++;
        end
      end
      t = keys[p]; keys[p] = keys[e-1]; keys[e-1] = t;
      return (p == b) ? b + 1 : p;
    endfunction

    function status_e sort_keys();
      int unsigned fill, b, e, s;
      if (held <= 1) return ST_TOO_SHORT;
      if (held <= ins_limit) begin
        insertion_run(0, held);
        return ST_SORTED;
      end
      fill = 1;
      ranges_lo[0] = 0;
      ranges_hi[0] = held;
      while (fill > 0) begin
        fill--;
        b = ranges_lo[fill];
        e = ranges_hi[fill];
        if (e - b <= 1) continue;
        if (e - b <= ins_limit) begin
          insertion_run(b, e);
          continue;
        end
        s = partition(b, e);
        if (fill + 2 > STACK_DEPTH) return ST_OVERFLOW;
        // smaller part goes underneath
        if (s - b < e - s) begin
          ranges_lo[fill] = b; ranges_hi[fill] = s;
          ranges_lo[fill+1] = s; ranges_hi[fill+1] = e;
        end else begin
          ranges_lo[fill] = s; ranges_hi[fill] = e;
          ranges_lo[fill+1] = b; ranges_hi[fill+1] = s;
        end
        fill += 2;
      end
      return ST_SORTED;
    endfunction

    function void note_word(bit mode, logic [31:0] key, bit last, logic [9:0] idx);
      sort_result_t r;
      bit full;
      r.value = '0;
      if (!mode) begin
        if (load_finished) begin
          held = 0;
          load_finished = 0;
        end
        full = (held >= MAX_KEYS);
        if (!full) begin
          keys[held] = key;
          held++;
        end
        if (last) begin
          r.status = sort_keys();
          load_finished = 1;
        end else begin
          r.status = full ? ST_FULL : ST_STORED;
        end
      end else if (idx < held) begin
        r.value = keys[idx];
        r.status = ST_READ_OK;
      end else begin
        r.status = ST_BAD_INDEX;
      end
      r.count = held[10:0];
      awaited.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_word(logic [47:0] w);
      sort_result_t r;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word %h", w));
        return;
      end
      r = awaited.pop_front();
      if (w[31:0] !== r.value)
        report($sformatf("value %h, expected %h", w[31:0], r.value));
      if (w[34:32] !== r.status)
        report($sformatf("status %0d, expected %0d", w[34:32], r.status));
      if (w[45:35] !== r.count)
        report($sformatf("count %0d, expected %0d", w[45:35], r.count));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;

  quicksort_insertion_hybrid dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  sort_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;
  localparam int unsigned QUIET_LIMIT = 400000;

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      m_axis_tready <= 0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seen != holdoff_asked) begin
      holdoff_seen <= holdoff_asked;
      holdoff_left <= 300;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task send_word(bit mode, logic [31:0] key, bit last, logic [9:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'b0, idx, key};
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(mode, key, last, idx);
  endtask

  task drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task write_reg(cfg_idx_e r, logic [6:0] v);
    drain();
    cfg_we_i    <= 1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (r == CFG_SIGNED_KEYS) sb.signed_cmp = v[0];
    else sb.ins_limit = v;
  endtask

  task read_word(logic [9:0] idx);
    send_word(1, $urandom, $urandom_range(1), idx);
  endtask

  function logic [9:0] pick_index();
    if (sb.held > 0 && $urandom_range(9) < 8) return $urandom_range(sb.held - 1);
    return $urandom_range(1023);
  endfunction

  // shape: 0 random, 1 narrow range, 2 ascending as signed, 3 descending, 4 extremes
  function logic [31:0] make_key(int shape, int unsigned k);
    logic [31:0] ext [4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case (shape)
      0: return $urandom;
      1: return 32'h7FFF_FFFC + $urandom_range(7);
      2: return k * 3 - 100;
      3: return 32'h4000_0000 - k * 5;
      default: return ext[$urandom_range(3)];
    endcase
  endfunction

  task load_run(int unsigned n, int shape, int unsigned mid_reads);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < mid_reads) read_word(pick_index());
      send_word(0, make_key(shape, k), k == n - 1, $urandom);
    end
  endtask

  task random_phase(int unsigned words);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < words) begin
      case ($urandom_range(9))
        0: begin
          send_word(0, $urandom, $urandom_range(1), $urandom);
          sent++;
        end
        1, 2: begin
          read_word(pick_index());
          sent++;
        end
        default: begin
          n = ($urandom_range(19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
          load_run(n, $urandom_range(4), 10);
          repeat ($urandom_range(2, 6)) read_word(pick_index());
          sent += n + 4;
        end
      endcase
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty store, extremes unsigned then signed, single key
    read_word(0);
    load_run(5, 4, 0);
    send_word(0, 32'h0000_0001, 1, 10'h3FF);
    for (int i = 0; i < 3; i++) read_word(i);
    read_word(10'h3FF);
    write_reg(CFG_SIGNED_KEYS, 1);
    send_word(0, 32'h8000_0000, 0, 0);
    send_word(0, 32'h7FFF_FFFF, 0, 0);
    send_word(0, 32'hFFFF_FFFF, 0, 0);
    send_word(0, 32'h0000_0000, 1, 0);
    for (int i = 0; i < 5; i++) read_word(i);
    send_word(0, 32'h1234_5678, 1, 0);
    read_word(0);
    read_word(1);

    // ascending run with tiny cutoff blows the range stack
    write_reg(CFG_INS_THR, 2);
    load_run(70, 2, 0);
    for (int i = 0; i < 5; i++) read_word($urandom_range(69));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      case (ph)
        0: begin write_reg(CFG_SIGNED_KEYS, 0); write_reg(CFG_INS_THR, 64); end
        1: begin write_reg(CFG_SIGNED_KEYS, 1); write_reg(CFG_INS_THR, 0); end
        2: begin write_reg(CFG_SIGNED_KEYS, 0); write_reg(CFG_INS_THR, 127); end
        default: begin write_reg(CFG_SIGNED_KEYS, 1); write_reg(CFG_INS_THR, 16); end
      endcase
      random_phase(60);
      holdoff_asked++;
      random_phase(30);
      drain();
      random_phase(60);
      if (ph == 0) begin
        // fill the store, push at least one past it, then finish the load
        for (int i = 0; i < MAX_KEYS + 1; i++)
          send_word(0, $urandom, 0, $urandom);
        send_word(0, $urandom, 1, $urandom);
        for (int i = 0; i < 4; i++) read_word(pick_index());
      end
    end

    s_axis_tvalid <= 0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < QUIET_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.awaited.size() != 0) sb.report("results still outstanding");
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
